// ----- src/call_depth_trace_filter_macros.svh -----
`ifndef CALL_DEPTH_TRACE_FILTER_MACROS_SVH
`define CALL_DEPTH_TRACE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CDTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cdtf_pkg.sv -----
package cdtf_pkg;

    localparam int THREAD_W = 6;
    localparam int DEPTH_W  = 32;
    localparam int TIME_W   = 64;

    // s_tdata: thread_slot, time_ns, pad
    localparam int S_TDATA_W = 72;
    // m_tdata: out_thread, out_depth, out_time, pad
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - THREAD_W - DEPTH_W - TIME_W;

    localparam logic OP_ENTRY  = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN    = 2'd1;

endpackage

// ----- src/call_depth_trace_filter.sv -----
// Call-depth trace filter.
// s_* carries trace events: s_tuser is the opcode (0 entry, 1 return), s_tdata
// holds thread slot and timestamp. m_* carries records: m_tuser is 1 for a
// return record, m_tdata holds thread, zero-indexed depth and timestamp.
// cfg_* writes the depth limit (index 0) and the shortest reported call
// (index 1); cfg_ready is always high, writes are meant for idle periods only.
// Per-thread depth lives in a THREADS-deep RAM, start stamps with valid bits
// in a THREADS*STACK_SLOTS-deep RAM; both have a registered read.
// An event is taken in S_IDLE, the thread word is read and then updated: an
// entry record is written to the output register from S_THR, a return
// record from S_START (the start RAM read follows the thread RAM read). The
// next event is taken once the current one is done, so a new event is not
// taken while an earlier one is still in S_THR or S_START.
// After reset a clearing pass writes every start RAM entry (THREADS*STACK_SLOTS,
// 4096 by default) and every thread RAM entry once, with s_tready low.
// When m_tready is low with a record waiting, an event that would emit a new
// record waits in its last step; events that emit nothing still complete.
`include "call_depth_trace_filter_macros.svh"

module call_depth_trace_filter
    import cdtf_pkg::*;
#(
    parameter int THREADS     = 64,
    parameter int STACK_SLOTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // thread_slot, time_ns, zero pad
    input  logic                  s_tuser,  // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // out_thread, out_depth, out_time, zero pad
    output logic                  m_tuser,  // out_is_return
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TAW         = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int MOD_W       = $clog2(STACK_SLOTS);
    localparam int SLOTS_TOTAL = THREADS * STACK_SLOTS;
    localparam int SLOT_AW     = $clog2(SLOTS_TOTAL);
    localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(STACK_SLOTS - 1);
    // (2^32 - 1) mod STACK_SLOTS: slot of depth after wrapping below zero
    localparam logic [MOD_W-1:0] MOD_WRAP = MOD_W'(64'(32'hFFFF_FFFF) % 64'(STACK_SLOTS));
    localparam logic [SLOT_AW-1:0] CLR_LAST = SLOT_AW'(SLOTS_TOTAL - 1);
    localparam int ST_W = TIME_W + 1;

    typedef struct packed {
        logic               known;
        logic [DEPTH_W-1:0] depth;
        logic [MOD_W-1:0]   smod;
    } thr_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_THR,
        S_START
    } state_t;

    function automatic logic [MOD_W-1:0] mod_inc(input logic [DEPTH_W-1:0] d,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] r;
        if (d == '1 || m == MOD_LAST)
            r = '0;
        else
            r = m + 1'b1;
        return r;
    endfunction

    function automatic logic [MOD_W-1:0] mod_dec(input logic [DEPTH_W-1:0] d,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] r;
        if (d == '0)
            r = MOD_WRAP;
        else if (m == '0)
            r = MOD_LAST;
        else
            r = m - 1'b1;
        return r;
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_of(input logic [TAW-1:0] t,
                                                   input logic [MOD_W-1:0] m);
        return SLOT_AW'(t) * SLOT_AW'(STACK_SLOTS) + SLOT_AW'(m);
    endfunction

    state_t               state_reg, state_next;
    logic [SLOT_AW-1:0]   clr_reg;
    logic [DEPTH_W-1:0]   depth_limit_reg;
    logic [TIME_W-1:0]    min_dur_reg;
    logic                 m_tvalid_reg;
    logic                 op_reg;
    logic [THREAD_W-1:0]  tid_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [THREAD_W-1:0]  out_thread_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;
    logic [TIME_W-1:0]    out_time_reg;
    logic                 out_ret_reg;

    logic [THREAD_W-1:0]  s_thread;
    logic [TIME_W-1:0]    s_time;
    logic                 in_range;
    logic                 accept;
    logic                 out_free;

    logic                 thr_we;
    logic [TAW-1:0]       thr_waddr;
    thr_t                 thr_wdata;
    logic [$bits(thr_t)-1:0] thr_rdata;
    thr_t                 thr_cur;
    logic                 st_we;
    logic [SLOT_AW-1:0]   st_waddr;
    logic [ST_W-1:0]      st_wdata;
    logic                 st_re;
    logic [ST_W-1:0]      st_rdata;

    logic [TAW-1:0]       taddr;
    logic [DEPTH_W-1:0]   inc_depth;
    logic [MOD_W-1:0]     inc_mod;
    logic [DEPTH_W-1:0]   dec_depth;
    logic [MOD_W-1:0]     dec_mod;
    logic [DEPTH_W-1:0]   new_depth;
    logic [MOD_W-1:0]     new_mod;
    logic [TIME_W-1:0]    duration;

    logic                 emit;
    logic [DEPTH_W-1:0]   emit_depth;
    logic                 emit_ret;

    assign s_thread  = s_tdata[THREAD_W-1:0];
    assign s_time    = s_tdata[THREAD_W +: TIME_W];
    assign in_range  = 32'(s_thread) < 32'(THREADS);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign thr_cur   = thr_t'(thr_rdata);
    assign taddr     = TAW'(tid_reg);
    assign inc_depth = thr_cur.depth + 1'b1;
    assign inc_mod   = mod_inc(thr_cur.depth, thr_cur.smod);
    assign dec_depth = thr_cur.depth - 1'b1;
    assign dec_mod   = mod_dec(thr_cur.depth, thr_cur.smod);
    assign new_depth = thr_cur.known ? inc_depth : '0;
    assign new_mod   = thr_cur.known ? inc_mod : '0;
    assign duration  = time_reg - st_rdata[TIME_W-1:0];

    cdtf_ram #(
        .WIDTH ($bits(thr_t)),
        .DEPTH (THREADS)
    ) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (thr_waddr),
        .wdata (thr_wdata),
        .re    (accept),
        .raddr (TAW'(s_thread)),
        .rdata (thr_rdata)
    );

    cdtf_ram #(
        .WIDTH (ST_W),
        .DEPTH (SLOTS_TOTAL)
    ) u_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (slot_of(taddr, thr_cur.smod)),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        thr_we     = 1'b0;
        thr_waddr  = taddr;
        thr_wdata  = '0;
        st_we      = 1'b0;
        st_waddr   = slot_of(taddr, new_mod);
        st_wdata   = '0;
        st_re      = 1'b0;
        emit       = 1'b0;
        emit_depth = thr_cur.depth;
        emit_ret   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                if (32'(clr_reg) < 32'(THREADS))
                begin
                    thr_we    = 1'b1;
                    thr_waddr = TAW'(clr_reg);
                end
                if (clr_reg == CLR_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept && in_range)
                    state_next = S_THR;
            end
            S_THR:
            begin
                if (op_reg == OP_ENTRY)
                begin
                    if (thr_cur.known && (thr_cur.depth + 32'd2) > depth_limit_reg)
                    begin
                        thr_we     = 1'b1;
                        thr_wdata  = '{known: 1'b1, depth: inc_depth, smod: inc_mod};
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        thr_we     = 1'b1;
                        thr_wdata  = '{known: 1'b1, depth: new_depth, smod: new_mod};
                        st_we      = 1'b1;
                        st_wdata   = {1'b1, time_reg};
                        emit       = 1'b1;
                        emit_depth = new_depth;
                        state_next = S_IDLE;
                    end
                end
                else if (!thr_cur.known)
                begin
                    state_next = S_IDLE;
                end
                else if ((thr_cur.depth + 32'd1) > depth_limit_reg)
                begin
                    thr_we     = 1'b1;
                    thr_wdata  = '{known: 1'b1, depth: dec_depth, smod: dec_mod};
                    state_next = S_IDLE;
                end
                else
                begin
                    st_re      = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!st_rdata[TIME_W])
                begin
                    state_next = S_IDLE;
                end
                else if (duration < min_dur_reg)
                begin
                    thr_we     = 1'b1;
                    thr_wdata  = '{known: 1'b1, depth: dec_depth, smod: dec_mod};
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    thr_we     = 1'b1;
                    thr_wdata  = '{known: 1'b1, depth: dec_depth, smod: dec_mod};
                    emit       = 1'b1;
                    emit_ret   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            depth_limit_reg <= '0;
            min_dur_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[DEPTH_W-1:0];
                    REG_MIN_SPAN:    min_dur_reg     <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            tid_reg  <= s_thread;
            time_reg <= s_time;
        end
        if (emit)
        begin
            out_thread_reg <= tid_reg;
            out_depth_reg  <= emit_depth;
            out_time_reg   <= time_reg;
            out_ret_reg    <= emit_ret;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_time_reg, out_depth_reg, out_thread_reg};
    assign m_tuser  = out_ret_reg;

    `CDTF_ASSERT_NOW(a_clear_invalidates, state_reg == S_CLEAR,
        st_we && !st_wdata[TIME_W], "clearing pass must write invalid start entries")
    `CDTF_ASSERT_NOW(a_start_with_thread, st_we && state_reg != S_CLEAR,
        thr_we && thr_wdata.known, "start stamp written without thread update")
    `CDTF_ASSERT_NOW(a_start_read_known, st_re,
        thr_cur.known && op_reg == OP_RETURN, "start lookup for unknown thread or entry")
    `CDTF_ASSERT_NEXT(a_accept_reads_thread, accept && in_range,
        state_reg == S_THR, "accepted event did not proceed to thread lookup")
    `CDTF_ASSERT_NEXT(a_emit_shows, emit, m_tvalid, "record lost after emit")

endmodule

// ----- src/cdtf_ram.sv -----
module cdtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cdtf_pkg::*;

    localparam int THREADS     = 64;
    localparam int STACK_SLOTS = 64;
    localparam int DRAIN       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [DEPTH_W-1:0]  depth;
        logic [TIME_W-1:0]   stamp;
        logic                is_return;
    } record_t;

    class call_record_board;
        logic [DEPTH_W-1:0] depth_limit;
        logic [TIME_W-1:0]  min_span;
        bit                 known[THREADS];
        logic [DEPTH_W-1:0] depth[THREADS];
        bit                 start_ok[THREADS*STACK_SLOTS];
        logic [TIME_W-1:0]  start_at[THREADS*STACK_SLOTS];
        record_t            pending[$];
        int                 failures;
        int                 events_seen;
        int                 records_seen;
        int                 settings;

        function new();
            depth_limit = '0;
            min_span    = '0;
            foreach (known[i])
            begin
                known[i] = 1'b0;
                depth[i] = '0;
            end
            foreach (start_ok[i])
                start_ok[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            settings++;
            if (idx == REG_DEPTH_LIMIT)
                depth_limit = val[DEPTH_W-1:0];
            else if (idx == REG_MIN_SPAN)
                min_span = val;
        endfunction

        function void take_event(logic op, logic [THREAD_W-1:0] tid, logic [TIME_W-1:0] now);
            logic [DEPTH_W-1:0] d;
            logic [DEPTH_W-1:0] reach;
            logic [TIME_W-1:0]  span;
            int                 slot;
            events_seen++;
            d = depth[tid];
            if (op == OP_ENTRY)
            begin
                reach = d + 32'd2;
                if (known[tid] && reach > depth_limit)
                begin
                    depth[tid] = d + 32'd1;
                    return;
                end
                d = known[tid] ? d + 32'd1 : '0;
                known[tid] = 1'b1;
                depth[tid] = d;
                slot = tid * STACK_SLOTS + d % STACK_SLOTS;
                start_at[slot] = now;
                start_ok[slot] = 1'b1;
                pending.push_back('{tid, d, now, 1'b0});
                return;
            end
            if (!known[tid])
                return;
            reach = d + 32'd1;
            if (reach > depth_limit)
            begin
                depth[tid] = d - 32'd1;
                return;
            end
            slot = tid * STACK_SLOTS + d % STACK_SLOTS;
            if (!start_ok[slot])
                return;
            span = now - start_at[slot];
            if (span >= min_span)
                pending.push_back('{tid, d, now, 1'b1});
            depth[tid] = d - 32'd1;
        endfunction

        function void check_record(record_t got);
            record_t want;
            records_seen++;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected record: thread %0d depth %0d time %h ret %0b",
                             got.thread, got.depth, got.stamp, got.is_return);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("record mismatch, want: thread %0d depth %0d time %h ret %0b",
                             want.thread, want.depth, want.stamp, want.is_return);
                    $display("                 got:  thread %0d depth %0d time %h ret %0b",
                             got.thread, got.depth, got.stamp, got.is_return);
                end
            end
        endfunction

        function void close_out();
            if (pending.size() != 0)
            begin
                $display("%0d expected records never arrived", pending.size());
                failures += pending.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // thread_slot, time_ns, zero pad
    logic                  s_tuser   = 1'b0;  // opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // out_thread, out_depth, out_time, zero pad
    logic                  m_tuser;  // out_is_return
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    call_record_board  board = new();
    int                src_idle_pct;
    int                sink_idle_pct;
    bit                hold_req;
    int                cycle_count;
    logic [TIME_W-1:0] clock_ns;

    call_depth_trace_filter #(
        .THREADS     (THREADS),
        .STACK_SLOTS (STACK_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // record sink; long hold-off when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_record('{m_tdata[THREAD_W-1:0],
                                 m_tdata[THREAD_W +: DEPTH_W],
                                 m_tdata[THREAD_W+DEPTH_W +: TIME_W],
                                 m_tuser});
    end

    task automatic post_event(input logic op, input logic [THREAD_W-1:0] tid,
                              input logic [TIME_W-1:0] now);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-THREAD_W-TIME_W){1'b0}}, now, tid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.take_event(op, tid, now);
    endtask

    // stop offering, wait for all records, then let silent events finish
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic configure(input logic [DEPTH_W-1:0] max_d, input logic [TIME_W-1:0] min_d,
                             input bit spare);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        int                    n;
        idx[0] = REG_DEPTH_LIMIT;
        val[0] = {$urandom, max_d};
        idx[1] = REG_MIN_SPAN;
        val[1] = min_d;
        idx[2] = REG_SPARE_2;
        val[2] = {$urandom, $urandom};
        idx[3] = REG_SPARE_3;
        val[3] = {$urandom, $urandom};
        n = spare ? 4 : 2;
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.write_reg(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // nested call/return traffic on a few threads, with some noise
    task automatic run_phase(input logic [DEPTH_W-1:0] max_d, input logic [TIME_W-1:0] min_d,
                             input int n, input int pool_n, input int entry_pct,
                             input bit squeeze);
        logic [THREAD_W-1:0] pool[8];
        logic                op;
        settle();
        configure(max_d, min_d, 1'b0);
        foreach (pool[i])
            pool[i] = THREAD_W'($urandom_range(THREADS-1));
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                post_event(1'($urandom_range(1)), THREAD_W'($urandom_range(THREADS-1)),
                           {$urandom, $urandom});
            else
            begin
                clock_ns += $urandom_range(40);
                op = ($urandom_range(99) < entry_pct) ? OP_ENTRY : OP_RETURN;
                post_event(op, pool[$urandom_range(pool_n-1)], clock_ns);
            end
        end
    endtask

    initial
    begin
        src_idle_pct  = 32;
        sink_idle_pct = 75;
        clock_ns      = 64'd5000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: nothing past depth 0 is reported, depth wraps below 0
        post_event(OP_ENTRY,  6'd0, 64'd0);
        post_event(OP_RETURN, 6'd5, 64'd1);
        post_event(OP_ENTRY,  6'd0, 64'd2);
        post_event(OP_RETURN, 6'd0, 64'd3);
        post_event(OP_RETURN, 6'd0, 64'd4);
        post_event(OP_ENTRY,  6'd0, 64'd5);
        post_event(OP_RETURN, 6'd0, 64'd6);

        // everything reported; wrapped duration; return with no start
        settle();
        configure('1, '0, 1'b1);
        post_event(OP_ENTRY,  6'd63, '1);
        post_event(OP_RETURN, 6'd63, '0);
        post_event(OP_ENTRY,  6'd1, 64'd10);
        post_event(OP_ENTRY,  6'd1, 64'd20);
        post_event(OP_RETURN, 6'd1, 64'd30);
        post_event(OP_RETURN, 6'd1, 64'd40);
        post_event(OP_RETURN, 6'd1, 64'd50);

        // short returns and depth limit
        settle();
        configure(32'd3, 64'd100, 1'b0);
        post_event(OP_ENTRY,  6'd2, 64'd1000);
        post_event(OP_RETURN, 6'd2, 64'd1050);
        post_event(OP_ENTRY,  6'd2, 64'd2000);
        post_event(OP_ENTRY,  6'd2, 64'd2100);
        post_event(OP_ENTRY,  6'd2, 64'd2200);
        post_event(OP_ENTRY,  6'd2, 64'd2300);
        post_event(OP_RETURN, 6'd2, 64'd2400);
        post_event(OP_RETURN, 6'd2, 64'd2600);

        settle();
        configure(32'd5, '1, 1'b0);
        post_event(OP_ENTRY,  6'd3, '0);
        post_event(OP_RETURN, 6'd3, '1);
        post_event(OP_ENTRY,  6'd3, 64'd5);
        post_event(OP_RETURN, 6'd3, 64'd6);

        run_phase('1, '0, 50, 6, 55, 1'b1);
        run_phase(32'd3, 64'($urandom_range(40)), 50, 6, 55, 1'b0);
        run_phase('0, '0, 50, 6, 55, 1'b0);
        src_idle_pct  = 75;
        sink_idle_pct = 32;
        run_phase(32'd70, 64'($urandom_range(40)), 90, 1, 90, 1'b0);
        run_phase($urandom, '1, 50, 3, 40, 1'b0);
        run_phase(32'd10, 64'($urandom_range(60)), 50, 6, 55, 1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(32'd1, '0, 50, 4, 55, 1'b0);
        run_phase('1, 64'($urandom_range(30)), 50, 6, 50, 1'b0);

        settle();
        board.close_out();
        $display("run covered %0d trace events under %0d register writes, %0d records checked",
                 board.events_seen, board.settings, board.records_seen);
        $display("depth limits 0 to max, wrapped depths and durations, one long output stall");
        if (board.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
